// ----- rtl/core/vwd_pkg.sv -----
`default_nettype none
package vwd_pkg;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_FACE   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNSEEN = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;
  localparam logic [31:0] PRIME_Z = 32'd83492791;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLR,
    B_PROBE,
    B_CMP,
    B_FACE,
    B_OUT
  } back_state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] kx;
    logic [31:0] ky;
    logic [31:0] kz;
    logic [31:0] hash;
    logic [11:0] ca;
    logic [11:0] cb;
    logic [11:0] cc;
  } work_t;

  typedef struct packed {
    op_t         kind;
    logic [11:0] new_index;
    logic        is_new;
    logic [11:0] face_a;
    logic [11:0] face_b;
    logic [11:0] face_c;
    logic        face_kept;
    status_t     status;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/vwd_front.sv -----
`default_nettype none
module vwd_front import vwd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic        [1:0]  op,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic        [11:0] corner_a,
  input  wire logic        [11:0] corner_b,
  input  wire logic        [11:0] corner_c,
  input  wire logic        [31:0] inv_eps,
  input  wire logic               q_full,
  output logic                    q_push,
  output work_t                   q_data
);

  front_state_t state_r, state_nxt;
  logic [2:0]   step_r, step_nxt;
  op_t          op_r;
  logic [31:0]  px_r, py_r, pz_r;
  logic [11:0]  ca_r, cb_r, cc_r;
  logic [63:0]  prod_r, prod_nxt;
  logic [31:0]  kx_r, ky_r, kz_r, hash_r;
  logic [31:0]  kx_nxt, ky_nxt, kz_nxt, hash_nxt;
  logic [31:0]  mul_a, mul_b, key_src;
  logic         accept;

  function automatic logic [31:0] magnitude(input logic [31:0] p);
    magnitude = p[31] ? (~p + 32'd1) : p;
  endfunction

  // round half away from zero on the Q32.32 product, then saturate
  function automatic logic [31:0] grid_key(input logic [63:0] prod, input logic neg);
    logic [33:0] sum;
    logic [32:0] q;
    sum = {1'b0, prod[63:31]} + 34'd1;
    q   = sum[33:1];
    if (neg) begin
      if (q > 33'h1_0000_0000 >> 1) q = 33'h0_8000_0000;
      grid_key = ~q[31:0] + 32'd1;
    end else begin
      if (q > 33'h0_7FFF_FFFF) q = 33'h0_7FFF_FFFF;
      grid_key = q[31:0];
    end
  endfunction

  assign in_full = (state_r != F_IDLE);
  assign accept  = in_push && !in_full;

  always_comb begin
    case (step_r)
      3'd0:    begin mul_a = magnitude(px_r); mul_b = inv_eps; end
      3'd1:    begin mul_a = magnitude(py_r); mul_b = inv_eps; end
      3'd2:    begin mul_a = magnitude(pz_r); mul_b = inv_eps; end
      3'd3:    begin mul_a = kx_r;            mul_b = PRIME_X; end
      3'd4:    begin mul_a = ky_r;            mul_b = PRIME_Y; end
      3'd5:    begin mul_a = kz_r;            mul_b = PRIME_Z; end
      default: begin mul_a = '0;              mul_b = '0;      end
    endcase
    case (step_r)
      3'd1:    key_src = px_r;
      3'd2:    key_src = py_r;
      default: key_src = pz_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    kx_nxt    = kx_r;
    ky_nxt    = ky_r;
    kz_nxt    = kz_r;
    hash_nxt  = hash_r;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          step_nxt = 3'd0;
          if (op_t'(op) == OP_VERTEX && inv_eps != 32'd0) begin
            state_nxt = F_CALC;
          end else if (op_t'(op) != OP_NONE) begin
            state_nxt = F_PUSH;
          end
        end
      end
      F_CALC: begin
        prod_nxt = mul_a * mul_b;
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd1:    kx_nxt   = grid_key(prod_r, key_src[31]);
          3'd2:    ky_nxt   = grid_key(prod_r, key_src[31]);
          3'd3:    kz_nxt   = grid_key(prod_r, key_src[31]);
          3'd4:    hash_nxt = prod_r[31:0];
          3'd5:    hash_nxt = hash_r ^ prod_r[31:0];
          3'd6:    begin
            hash_nxt  = hash_r ^ prod_r[31:0];
            state_nxt = F_PUSH;
          end
          default: ;
        endcase
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    q_data      = '0;
    q_data.op   = op_r;
    q_data.kx   = kx_r;
    q_data.ky   = ky_r;
    q_data.kz   = kz_r;
    q_data.hash = hash_r;
    q_data.ca   = ca_r;
    q_data.cb   = cb_r;
    q_data.cc   = cc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_t'(op);
      px_r <= pos_x;
      py_r <= pos_y;
      pz_r <= pos_z;
      ca_r <= corner_a;
      cb_r <= corner_b;
      cc_r <= corner_c;
    end
    prod_r <= prod_nxt;
    kx_r   <= kx_nxt;
    ky_r   <= ky_nxt;
    kz_r   <= kz_nxt;
    hash_r <= hash_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/vwd_queue.sv -----
`default_nettype none
module vwd_queue import vwd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire work_t push_data,
  output logic       full,
  input  wire logic  pop,
  output work_t      pop_data,
  output logic       empty
);

  work_t       mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr_r <= ~wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ----- rtl/core/vwd_back.sv -----
`default_nettype none
module vwd_back import vwd_pkg::*; #(
  parameter int MAX_VERTS   = 4096,
  parameter int TABLE_SLOTS = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] inv_eps,
  input  wire logic        q_empty,
  input  wire work_t       q_data,
  output logic             q_pop,
  input  wire logic        out_pop,
  output logic             out_empty,
  output result_t          out_res
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int VIDX_W = $clog2(MAX_VERTS);
  localparam int CNT_W  = VIDX_W + 1;

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt, uniq_r, uniq_nxt;
  work_t             w_r, w_nxt;
  logic [SLOT_W-1:0] paddr_r, paddr_nxt;
  logic [SLOT_W:0]   pcnt_r, pcnt_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [VIDX_W-1:0] ra_r, ra_nxt, rb_r, rb_nxt;
  result_t           res_r, res_nxt, out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              init_r, init_nxt;

  logic [95:0]       key_mem  [TABLE_SLOTS];
  logic [VIDX_W-1:0] sidx_mem [TABLE_SLOTS];
  logic              used_mem [TABLE_SLOTS];
  logic [VIDX_W-1:0] o2n_mem  [MAX_VERTS];

  logic [95:0]       key_rd_r;
  logic [VIDX_W-1:0] sidx_rd_r, o2n_rd_r;
  logic              used_rd_r;

  logic              slot_we, used_we, used_wd, o2n_we;
  logic [VIDX_W-1:0] o2n_wd, o2n_raddr;
  logic [95:0]       w_key;
  logic              q_unseen, w_unseen, last_slot;

  assign out_empty = !out_valid_r;
  assign out_res   = out_r;
  assign w_key     = {w_r.kx, w_r.ky, w_r.kz};
  assign last_slot = (pcnt_r == (SLOT_W+1)'(TABLE_SLOTS - 1));
  assign q_unseen  = (32'(q_data.ca) >= 32'(seen_r)) || (32'(q_data.cb) >= 32'(seen_r)) ||
                     (32'(q_data.cc) >= 32'(seen_r));
  assign w_unseen  = 1'b0;

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    uniq_nxt      = uniq_r;
    w_nxt         = w_r;
    paddr_nxt     = paddr_r;
    pcnt_nxt      = pcnt_r;
    k_nxt         = k_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    slot_we       = 1'b0;
    used_we       = 1'b0;
    used_wd       = 1'b0;
    o2n_we        = 1'b0;
    o2n_wd        = uniq_r[VIDX_W-1:0];
    case (k_r)
      2'd1:    o2n_raddr = VIDX_W'(w_r.cb);
      2'd2:    o2n_raddr = VIDX_W'(w_r.cc);
      default: o2n_raddr = VIDX_W'(w_r.ca);
    endcase
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          w_nxt        = q_data;
          res_nxt      = '0;
          res_nxt.kind = q_data.op;
          case (q_data.op)
            OP_CLEAR: begin
              seen_nxt  = '0;
              uniq_nxt  = '0;
              paddr_nxt = '0;
              pcnt_nxt  = '0;
              state_nxt = B_CLR;
            end
            OP_VERTEX: begin
              if (32'(seen_r) >= 32'(MAX_VERTS)) begin
                res_nxt.status = ST_FULL;
                state_nxt      = B_OUT;
              end else if (inv_eps == 32'd0) begin
                o2n_we            = 1'b1;
                seen_nxt          = seen_r + CNT_W'(1);
                uniq_nxt          = uniq_r + CNT_W'(1);
                res_nxt.new_index = 12'(uniq_r[VIDX_W-1:0]);
                res_nxt.is_new    = 1'b1;
                state_nxt         = B_OUT;
              end else begin
                paddr_nxt = q_data.hash[SLOT_W-1:0];
                pcnt_nxt  = '0;
                state_nxt = B_PROBE;
              end
            end
            OP_FACE: begin
              if (q_unseen) begin
                res_nxt.status = ST_UNSEEN;
                state_nxt      = B_OUT;
              end else if (inv_eps == 32'd0) begin
                res_nxt.face_a    = q_data.ca;
                res_nxt.face_b    = q_data.cb;
                res_nxt.face_c    = q_data.cc;
                res_nxt.face_kept = 1'b1;
                state_nxt         = B_OUT;
              end else begin
                k_nxt     = 2'd0;
                state_nxt = B_FACE;
              end
            end
            default: ;
          endcase
        end
      end
      B_CLR: begin
        used_we   = 1'b1;
        paddr_nxt = paddr_r + SLOT_W'(1);
        pcnt_nxt  = pcnt_r + (SLOT_W+1)'(1);
        if (last_slot) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = B_IDLE;
          end else begin
            state_nxt = B_OUT;
          end
        end
      end
      B_PROBE: state_nxt = B_CMP;
      B_CMP: begin
        if (!used_rd_r) begin
          slot_we           = 1'b1;
          used_we           = 1'b1;
          used_wd           = 1'b1;
          o2n_we            = 1'b1;
          seen_nxt          = seen_r + CNT_W'(1);
          uniq_nxt          = uniq_r + CNT_W'(1);
          res_nxt.new_index = 12'(uniq_r[VIDX_W-1:0]);
          res_nxt.is_new    = 1'b1;
          state_nxt         = B_OUT;
        end else if (key_rd_r == w_key) begin
          o2n_we            = 1'b1;
          o2n_wd            = sidx_rd_r;
          seen_nxt          = seen_r + CNT_W'(1);
          res_nxt.new_index = 12'(sidx_rd_r);
          state_nxt         = B_OUT;
        end else if (last_slot) begin
          res_nxt.status = ST_FULL;
          state_nxt      = B_OUT;
        end else begin
          paddr_nxt = paddr_r + SLOT_W'(1);
          pcnt_nxt  = pcnt_r + (SLOT_W+1)'(1);
          state_nxt = B_PROBE;
        end
      end
      B_FACE: begin
        k_nxt = k_r + 2'd1;
        case (k_r)
          2'd1: ra_nxt = o2n_rd_r;
          2'd2: rb_nxt = o2n_rd_r;
          2'd3: begin
            res_nxt.face_a    = 12'(ra_r);
            res_nxt.face_b    = 12'(rb_r);
            res_nxt.face_c    = 12'(o2n_rd_r);
            res_nxt.face_kept = (ra_r != rb_r) && (rb_r != o2n_rd_r) && (o2n_rd_r != ra_r);
            state_nxt         = B_OUT;
          end
          default: ;
        endcase
      end
      B_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    if (w_unseen) state_nxt = B_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      seen_r      <= '0;
      uniq_r      <= '0;
      paddr_r     <= '0;
      pcnt_r      <= '0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
      init_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      uniq_r      <= uniq_nxt;
      paddr_r     <= paddr_nxt;
      pcnt_r      <= pcnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      init_r      <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      key_mem[paddr_r]  <= w_key;
      sidx_mem[paddr_r] <= uniq_r[VIDX_W-1:0];
    end
    if (used_we) used_mem[paddr_r] <= used_wd;
    if (o2n_we) o2n_mem[seen_r[VIDX_W-1:0]] <= o2n_wd;
    key_rd_r  <= key_mem[paddr_r];
    sidx_rd_r <= sidx_mem[paddr_r];
    used_rd_r <= used_mem[paddr_r];
    o2n_rd_r  <= o2n_mem[o2n_raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/vertex_weld_dedup.sv -----
// Vertex welding with a spatial hash.
// Input queue side: drive op, pos_x/y/z (vertex) or corner_a/b/c (face) and
// raise in_push; a transfer happens on a clock edge with in_push high and
// in_full low. Result queue side: while out_empty is low the oldest result is
// on the out_ ports; a transfer happens with out_pop high and out_empty low.
// Config: cfg_valid/cfg_ready write inv_epsilon (cfg_ready is always high);
// write it only while the block is idle.
// The front computes the three grid keys and the hash on one shared 32x32
// multiplier when welding is enabled; a two-entry queue feeds the back,
// which probes the slot memory with a registered read, then a compare,
// for each probe. A face reads the remap table once per corner. A clear
// op sweeps the used bits of all TABLE_SLOTS slots. The front takes a new
// input only once it has pushed the previous one into the queue.
// After reset the same sweep runs before the first item is processed;
// input transfers still queue up during it.
// When out_pop stays low the single result register holds, the back stalls,
// and the queue then the front fill and in_full rises.
`default_nettype none
module vertex_weld_dedup import vwd_pkg::*; #(
  parameter int MAX_VERTS   = 4096,
  parameter int TABLE_SLOTS = 8192
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic        [1:0]  in_op,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic        [11:0] in_corner_a,
  input  wire logic        [11:0] in_corner_b,
  input  wire logic        [11:0] in_corner_c,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic             [1:0]  out_kind,
  output logic             [11:0] out_new_index,
  output logic                    out_is_new,
  output logic             [11:0] out_face_a,
  output logic             [11:0] out_face_b,
  output logic             [11:0] out_face_c,
  output logic                    out_face_kept,
  output logic             [1:0]  out_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [31:0] cfg_inv_epsilon
);

  logic [31:0] inv_eps_r;
  logic        q_push, q_full, q_pop, q_empty;
  work_t       q_in, q_out;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_eps_r <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      inv_eps_r <= cfg_inv_epsilon;
    end
  end

  vwd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .op       (in_op),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .pos_z    (in_pos_z),
    .corner_a (in_corner_a),
    .corner_b (in_corner_b),
    .corner_c (in_corner_c),
    .inv_eps  (inv_eps_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  vwd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  vwd_back #(
    .MAX_VERTS   (MAX_VERTS),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .inv_eps   (inv_eps_r),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_kind      = res.kind;
  assign out_new_index = res.new_index;
  assign out_is_new    = res.is_new;
  assign out_face_a    = res.face_a;
  assign out_face_b    = res.face_b;
  assign out_face_c    = res.face_c;
  assign out_face_kept = res.face_kept;
  assign out_status    = res.status;

endmodule
`default_nettype wire
